// File: hw/rtl/aging_address_map_table_top_assert.svh
// Assertion macros for the table RTL.
// Each macro holds one concurrent assertion, clocked on clock and
// disabled while reset is high.
`ifndef AGING_ADDRESS_MAP_TABLE_TOP_ASSERT_SVH
`define AGING_ADDRESS_MAP_TABLE_TOP_ASSERT_SVH

// Same-cycle implication.
`define AAMT_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aamt assertion failed");

// Next-cycle implication.
`define AAMT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aamt assertion failed");

`endif

// File: hw/rtl/aamt_pkg.sv
// ----------------------------------------------------------------------------
// aamt_pkg
// Types and codes shared by the aging address map table modules.
// ----------------------------------------------------------------------------
package aamt_pkg;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_UPDATE = 2'd0;
   localparam logic [1:0] CMD_LOOKUP = 2'd1;
   localparam logic [1:0] CMD_TICK   = 2'd2;

   // Status codes of the response channel.
   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_MISS     = 3'd1;
   localparam logic [2:0] ST_INSERTED = 3'd2;
   localparam logic [2:0] ST_SAME     = 3'd3;
   localparam logic [2:0] ST_CHANGED  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_TICK     = 3'd6;

   localparam logic [15:0] LIFETIME_RESET = 16'd30000;
   localparam logic [6:0]  EXPIRED_MAX    = 7'd127;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] ip_key;
      logic [47:0] host_vid;
      logic [47:0] iface_vid;
      logic [47:0] host_mac;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] found_host_vid;
      logic [47:0] found_iface_vid;
      logic [47:0] found_host_mac;
      logic [6:0]  expired_count;
   } rsp_type;

   // Classified operation handed from the front end to the engine.
   typedef enum logic [1:0] {
      OP_UPDATE,
      OP_LOOKUP,
      OP_TICK,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] ip_key;
      logic [47:0] host_vid;
      logic [47:0] iface_vid;
      logic [47:0] host_mac;
   } cmd_type;

   // One table slot as held in memory.
   typedef struct packed {
      logic        valid;
      logic [15:0] life_left;
      logic [31:0] key;
      logic [47:0] host_vid;
      logic [47:0] iface_vid;
      logic [47:0] host_mac;
   } entry_type;

   typedef enum logic [2:0] {
      ENG_CLEAR,
      ENG_IDLE,
      ENG_SCAN,
      ENG_COMMIT,
      ENG_DONE
   } eng_state_type;

endpackage

// File: hw/rtl/aamt_front.sv
// ----------------------------------------------------------------------------
// aamt_front
// Accepts request transactions, classifies the command and queues them
// for the table engine in a two-entry queue.
// ----------------------------------------------------------------------------
module aamt_front
   import aamt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   input  logic    hold_off,
   output logic    req_full,
   output logic    cmd_valid,
   output cmd_type cmd_data,
   input  logic    cmd_pop
);

   cmd_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        accept;
   logic        take;
   cmd_type     classified;

   // Map the command code to an operation.
   always_comb begin
      classified.ip_key    = req_data.ip_key;
      classified.host_vid  = req_data.host_vid;
      classified.iface_vid = req_data.iface_vid;
      classified.host_mac  = req_data.host_mac;
      unique case (req_data.command)
         CMD_UPDATE: classified.op = OP_UPDATE;
         CMD_LOOKUP: classified.op = OP_LOOKUP;
         CMD_TICK:   classified.op = OP_TICK;
         default:    classified.op = OP_NONE;
      endcase
   end

   // Queue handshake and pointers.
   assign req_full  = (count_ff == 2'd2) || hold_off;
   assign accept    = req_push && !req_full;
   assign cmd_valid = (count_ff != 2'd0);
   assign take      = cmd_pop && cmd_valid;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = accept ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, accept} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// File: hw/rtl/aamt_engine.sv
// ----------------------------------------------------------------------------
// aamt_engine
// Carries out queued commands by walking the table memory one slot per cycle
// (unknown commands skip the walk), then commits an update and presents the response.
// ----------------------------------------------------------------------------
`include "aging_address_map_table_top_assert.svh"

module aamt_engine
   import aamt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   input  cmd_type     cmd_data,
   output logic        cmd_pop,
   input  logic [15:0] lifetime,
   output logic        clearing,
   output logic        res_valid,
   output rsp_type     res_data,
   input  logic        res_ready
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W:0]   CNT_END  = (IDX_W + 1)'(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

   entry_type           mem [TABLE_ENTRIES];
   entry_type           rd_data_ff;
   eng_state_type       state_ff, state_in;
   logic [IDX_W:0]      cnt_ff;
   logic                rd_vld_ff;
   logic [IDX_W-1:0]    rd_idx_ff;
   cmd_type             cmd_ff;
   logic                hit_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [47:0]         hit_hv_ff, hit_iv_ff, hit_mac_ff;
   logic                changed_ff;
   logic                free_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [6:0]          exp_cnt_ff;

   logic                issue;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;
   logic [15:0]         life_eff;
   logic [15:0]         life_dec;
   logic                key_match;
   logic                scan_last;

   assign life_eff  = (lifetime == 16'd0) ? 16'd1 : lifetime;
   assign life_dec  = (rd_data_ff.life_left != 16'd0) ? rd_data_ff.life_left - 16'd1 : 16'd0;
   assign key_match = rd_data_ff.valid && (rd_data_ff.key == cmd_ff.ip_key);
   assign issue     = (state_ff == ENG_SCAN) && (cnt_ff < CNT_END);
   assign scan_last = rd_vld_ff && (rd_idx_ff == IDX_LAST);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ENG_CLEAR: begin
            if (cnt_ff[IDX_W-1:0] == IDX_LAST) state_in = ENG_IDLE;
         end
         ENG_IDLE: begin
            if (cmd_valid) state_in = (cmd_data.op == OP_NONE) ? ENG_DONE : ENG_SCAN;
         end
         ENG_SCAN: begin
            if (scan_last) state_in = (cmd_ff.op == OP_UPDATE) ? ENG_COMMIT : ENG_DONE;
         end
         ENG_COMMIT: state_in = ENG_DONE;
         ENG_DONE: begin
            if (res_ready) state_in = ENG_IDLE;
         end
         default: state_in = ENG_CLEAR;
      endcase
   end

   // Outputs of the state machine: memory writes, queue pop, response.
   always_comb begin
      cmd_pop   = 1'b0;
      clearing  = 1'b0;
      res_valid = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = rd_idx_ff;
      mem_wdata = rd_data_ff;
      unique case (state_ff)
         ENG_CLEAR: begin
            clearing  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[IDX_W-1:0];
            mem_wdata = '0;
         end
         ENG_IDLE: cmd_pop = cmd_valid;
         ENG_SCAN: begin
            // A tick writes each valid slot back with its life counted down.
            if (cmd_ff.op == OP_TICK && rd_vld_ff && rd_data_ff.valid) begin
               mem_we              = 1'b1;
               mem_wdata.life_left = life_dec;
               mem_wdata.valid     = (life_dec != 16'd0);
            end
         end
         ENG_COMMIT: begin
            mem_we              = hit_ff || free_ff;
            mem_waddr           = hit_ff ? hit_idx_ff : free_idx_ff;
            mem_wdata.valid     = 1'b1;
            mem_wdata.life_left = life_eff;
            mem_wdata.key       = cmd_ff.ip_key;
            mem_wdata.host_vid  = cmd_ff.host_vid;
            mem_wdata.iface_vid = cmd_ff.iface_vid;
            mem_wdata.host_mac  = cmd_ff.host_mac;
         end
         ENG_DONE: res_valid = 1'b1;
         default: clearing = 1'b1;
      endcase
   end

   // Response contents from the scan results.
   always_comb begin
      res_data = '0;
      unique case (cmd_ff.op)
         OP_UPDATE: begin
            if (hit_ff)       res_data.status = changed_ff ? ST_CHANGED : ST_SAME;
            else if (free_ff) res_data.status = ST_INSERTED;
            else              res_data.status = ST_FULL;
         end
         OP_LOOKUP: begin
            res_data.status = hit_ff ? ST_HIT : ST_MISS;
            if (hit_ff) begin
               res_data.found_host_vid  = hit_hv_ff;
               res_data.found_iface_vid = hit_iv_ff;
               res_data.found_host_mac  = hit_mac_ff;
            end
         end
         OP_TICK: begin
            res_data.status        = ST_TICK;
            res_data.expired_count = exp_cnt_ff;
         end
         default: res_data.status = ST_MISS;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ENG_CLEAR;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= issue;
         if (state_ff == ENG_CLEAR || issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (state_ff == ENG_IDLE) begin
            cnt_ff <= '0;
         end
      end
   end

   // Scan bookkeeping.
   always_ff @(posedge clock) begin
      rd_idx_ff <= cnt_ff[IDX_W-1:0];
      if (cmd_pop) begin
         cmd_ff     <= cmd_data;
         hit_ff     <= 1'b0;
         free_ff    <= 1'b0;
         changed_ff <= 1'b0;
         exp_cnt_ff <= '0;
      end else if (state_ff == ENG_SCAN && rd_vld_ff) begin
         if (key_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= rd_idx_ff;
            hit_hv_ff  <= rd_data_ff.host_vid;
            hit_iv_ff  <= rd_data_ff.iface_vid;
            hit_mac_ff <= rd_data_ff.host_mac;
            changed_ff <= (rd_data_ff.host_vid != cmd_ff.host_vid)
                       || (rd_data_ff.iface_vid != cmd_ff.iface_vid)
                       || (rd_data_ff.host_mac != cmd_ff.host_mac);
         end
         if (!rd_data_ff.valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= rd_idx_ff;
         end
         if (cmd_ff.op == OP_TICK && rd_data_ff.valid && life_dec == 16'd0
             && exp_cnt_ff != EXPIRED_MAX) begin
            exp_cnt_ff <= exp_cnt_ff + 7'd1;
         end
      end
   end

   // Table memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[cnt_ff[IDX_W-1:0]];
   end

   `AAMT_ASSERT_NEXT(a_pop_starts_work, cmd_pop, (state_ff == ENG_SCAN || state_ff == ENG_DONE))
   `AAMT_ASSERT_IMP(a_scan_write_tick, (state_ff == ENG_SCAN && mem_we), (cmd_ff.op == OP_TICK))
   `AAMT_ASSERT_IMP(a_read_in_scan, rd_vld_ff, (state_ff == ENG_SCAN))

endmodule

// File: hw/rtl/aging_address_map_table_top.sv
// Flow: a request is queued in the front, taken by the engine when idle, walked
// over every slot (an update then commits; an unknown command skips the walk)
// and its response held in the response register. The engine works on one
// request at a time, since the single memory read port walks every slot for
// each one; the front queue holds up to two more. Reset: synchronous; a clearing
// pass follows, during which req_full stays high. Lifetime register resets to 30000.
// ----------------------------------------------------------------------------
// aging_address_map_table_top
// Aging address map table: front queue, table engine and response register.
// ----------------------------------------------------------------------------
module aging_address_map_table_top
   import aamt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   logic [15:0] lifetime_ff;
   logic        cmd_valid;
   cmd_type     cmd_data;
   logic        cmd_pop;
   logic        clearing;
   logic        res_valid;
   rsp_type     res_data;
   logic        res_ready;
   logic        out_vld_ff;
   rsp_type     out_data_ff;

   // Lifetime register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lifetime_ff <= LIFETIME_RESET;
      end else if (csr_we) begin
         lifetime_ff <= csr_wdata;
      end
   end

   aamt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .hold_off  (clearing),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop)
   );

   aamt_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_data),
      .cmd_pop   (cmd_pop),
      .lifetime  (lifetime_ff),
      .clearing  (clearing),
      .res_valid (res_valid),
      .res_data  (res_data),
      .res_ready (res_ready)
   );

   // Response register: holds one transaction until it is popped.
   assign res_ready = !out_vld_ff || rsp_pop;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (res_ready) begin
         out_vld_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         out_data_ff <= res_data;
      end
   end

endmodule

// File: dv/aamt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aamt_checker
// Watches the request, response and CSR ports of the aging address map
// table, keeps a shadow copy of the table to predict every response, and
// compares each popped response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module aamt_checker
   import aamt_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic        req_full,
   input  req_type     req_data,
   input  logic        rsp_empty,
   input  logic        rsp_pop,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata,
   output int          fail_count,
   output int          pending,
   output int          checked
);

   // Shadow table and lifetime register.
   logic        shadow_valid [TABLE_ENTRIES];
   logic [31:0] shadow_key   [TABLE_ENTRIES];
   logic [47:0] shadow_hv    [TABLE_ENTRIES];
   logic [47:0] shadow_iv    [TABLE_ENTRIES];
   logic [47:0] shadow_mac   [TABLE_ENTRIES];
   logic [15:0] shadow_life  [TABLE_ENTRIES];
   logic [15:0] lifetime;

   rsp_type expected_rsps[$];
   int      fails;
   int      n_checked;

   // Applies one request to the shadow table and returns its response.
   function automatic rsp_type predict_rsp(input req_type t);
      rsp_type     r;
      int          slot;
      logic [15:0] life;
      logic [6:0]  cnt;
      r    = '0;
      slot = -1;
      cnt  = '0;
      life = (lifetime == 16'd0) ? 16'd1 : lifetime;
      r.status = ST_MISS;
      if (t.command == CMD_UPDATE || t.command == CMD_LOOKUP) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && shadow_valid[i] && shadow_key[i] == t.ip_key) slot = i;
         end
      end
      if (t.command == CMD_UPDATE) begin
         if (slot >= 0) begin
            r.status = (shadow_hv[slot] != t.host_vid || shadow_iv[slot] != t.iface_vid ||
                        shadow_mac[slot] != t.host_mac) ? ST_CHANGED : ST_SAME;
         end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (slot < 0 && !shadow_valid[i]) slot = i;
            end
            if (slot >= 0) begin
               shadow_valid[slot] = 1'b1;
               shadow_key[slot]   = t.ip_key;
               r.status = ST_INSERTED;
            end else begin
               r.status = ST_FULL;
            end
         end
         if (slot >= 0) begin
            shadow_hv[slot]   = t.host_vid;
            shadow_iv[slot]   = t.iface_vid;
            shadow_mac[slot]  = t.host_mac;
            shadow_life[slot] = life;
         end
      end else if (t.command == CMD_LOOKUP) begin
         if (slot >= 0) begin
            r.status          = ST_HIT;
            r.found_host_vid  = shadow_hv[slot];
            r.found_iface_vid = shadow_iv[slot];
            r.found_host_mac  = shadow_mac[slot];
         end
      end else if (t.command == CMD_TICK) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (shadow_valid[i]) begin
               if (shadow_life[i] != 16'd0) shadow_life[i] = shadow_life[i] - 16'd1;
               if (shadow_life[i] == 16'd0) begin
                  shadow_valid[i] = 1'b0;
                  if (cnt < EXPIRED_MAX) cnt = cnt + 7'd1;
               end
            end
         end
         r.status = ST_TICK;
      end
      r.expired_count = cnt;
      return r;
   endfunction

   // Sample every transaction at the clock edge.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         lifetime = LIFETIME_RESET;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            shadow_valid[i] = 1'b0;
            shadow_life[i]  = '0;
         end
         expected_rsps.delete();
      end else begin
         if (csr_we) lifetime = csr_wdata;
         if (req_push && !req_full) expected_rsps.push_back(predict_rsp(req_data));
         if (rsp_pop && !rsp_empty) begin
            if (expected_rsps.size() == 0) begin
               $error("response with no transaction outstanding: status %0d",
                      rsp_data.status);
               fails++;
            end else begin
               e = expected_rsps.pop_front();
               n_checked++;
               if (rsp_data.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_data.status);
                  fails++;
               end
               if (rsp_data.found_host_vid !== e.found_host_vid) begin
                  $error("found_host_vid: expected %h, got %h",
                         e.found_host_vid, rsp_data.found_host_vid);
                  fails++;
               end
               if (rsp_data.found_iface_vid !== e.found_iface_vid) begin
                  $error("found_iface_vid: expected %h, got %h",
                         e.found_iface_vid, rsp_data.found_iface_vid);
                  fails++;
               end
               if (rsp_data.found_host_mac !== e.found_host_mac) begin
                  $error("found_host_mac: expected %h, got %h",
                         e.found_host_mac, rsp_data.found_host_mac);
                  fails++;
               end
               if (rsp_data.expired_count !== e.expired_count) begin
                  $error("expired_count: expected %0d, got %0d",
                         e.expired_count, rsp_data.expired_count);
                  fails++;
               end
            end
         end
      end
      fail_count <= fails;
      pending    <= expected_rsps.size();
      checked    <= n_checked;
   end

   initial begin
      fails      = 0;
      n_checked  = 0;
      fail_count = 0;
      pending    = 0;
      checked    = 0;
   end

endmodule

// File: dv/tb_aging_address_map_table_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_aging_address_map_table_top
// Drives directed and random update, lookup and tick traffic into the aging
// address map table over several lifetime settings and idling patterns; the
// checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_aging_address_map_table_top;
   import aamt_pkg::*;

   localparam int         ENTRIES     = 64;
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int         HOLD_CYCLES = 2000;
   localparam int         IDLE_LIMIT  = 20000;
   localparam int         SETTLE      = 80;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_empty;
   logic        rsp_pop;
   rsp_type     rsp_data;
   logic        csr_we;
   logic [15:0] csr_wdata;

   int fail_count;
   int pending;
   int checked;
   int send_idle_pct;
   int recv_stall_pct;
   bit hold_req;
   int hold_cnt;
   int idle_cycles;
   int sent;
   logic [31:0] key_pool [80];

   aging_address_map_table_top #(.TABLE_ENTRIES(ENTRIES)) uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   aamt_checker #(.TABLE_ENTRIES(ENTRIES)) u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending), .checked(checked)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Response side: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
         rsp_pop  <= 1'b0;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on cycles with no accepted transaction.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[aging_address_map_table_top] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offers one request transaction and waits until it is accepted.
   task automatic send_req(input logic [1:0] cmd, input logic [31:0] key,
                           input logic [47:0] hv, input logic [47:0] iv,
                           input logic [47:0] mac);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push          <= 1'b1;
      req_data.command  <= cmd;
      req_data.ip_key   <= key;
      req_data.host_vid <= hv;
      req_data.iface_vid <= iv;
      req_data.host_mac <= mac;
      do @(posedge clock); while (req_full);
      sent++;
   endtask

   // Waits until every predicted response has been popped, then settles.
   task automatic drain();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_lifetime(input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [47:0] rand48();
      return {$urandom, $urandom};
   endfunction

   // Random traffic over a pool of keys, so that hits, refreshes, a full
   // table and expiry all occur; a few commands carry fully random keys.
   task automatic random_phase(input int count);
      int          idx;
      int          sel;
      logic [1:0]  cmd;
      logic [31:0] key;
      logic [47:0] hv;
      logic [47:0] iv;
      logic [47:0] mac;
      for (int n = 0; n < count; n++) begin
         idx = $urandom_range(79);
         sel = $urandom_range(99);
         key = ($urandom_range(9) == 0) ? $urandom : key_pool[idx];
         if (sel < 45)      cmd = CMD_UPDATE;
         else if (sel < 80) cmd = CMD_LOOKUP;
         else if (sel < 95) cmd = CMD_TICK;
         else               cmd = CMD_UNKNOWN;
         if ($urandom_range(1) == 0) begin
            hv  = {16'(idx), 32'h5A5A_0000};
            iv  = {16'hC3C3, 32'(idx)};
            mac = {32'h0200_0000, 16'(idx)};
         end else begin
            hv  = rand48();
            iv  = rand48();
            mac = rand48();
         end
         send_req(cmd, key, hv, iv, mac);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_data       <= '0;
      csr_we         <= 1'b0;
      csr_wdata      <= '0;
      hold_req       = 1'b0;
      hold_cnt       = 0;
      idle_cycles    = 0;
      sent           = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      for (int i = 0; i < 80; i++) key_pool[i] = $urandom;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (req_full) @(posedge clock);

      // Directed: empty lookup, insert, refresh same and changed, extremes.
      send_req(CMD_LOOKUP, 32'h0, '0, '0, '0);
      send_req(CMD_UPDATE, 32'h0, '0, '0, '0);
      send_req(CMD_UPDATE, 32'h0, '0, '0, '0);
      send_req(CMD_UPDATE, 32'h0, '1, '1, '1);
      send_req(CMD_LOOKUP, 32'h0, '0, '0, '0);
      send_req(CMD_UPDATE, 32'hFFFF_FFFF, '1, '0, '1);
      send_req(CMD_LOOKUP, 32'hFFFF_FFFF, '1, '1, '1);
      send_req(CMD_UNKNOWN, '1, '1, '1, '1);
      send_req(CMD_TICK, '1, '1, '1, '1);
      drain();

      // Zero lifetime acts as one: the next tick expires both entries.
      write_lifetime(16'd0);
      send_req(CMD_UPDATE, 32'h0, '1, '1, '1);
      send_req(CMD_UPDATE, 32'hFFFF_FFFF, '1, '1, '1);
      send_req(CMD_TICK, '0, '0, '0, '0);
      send_req(CMD_LOOKUP, 32'h0, '0, '0, '0);
      send_req(CMD_TICK, '0, '0, '0, '0);
      drain();

      // Random phases across lifetimes and idling patterns.
      write_lifetime(16'd1);
      random_phase(180);
      drain();
      write_lifetime(16'd65535);
      send_idle_pct = 49;
      random_phase(180);
      drain();
      write_lifetime(16'd3);
      send_idle_pct  = 0;
      recv_stall_pct = 49;
      hold_req       = 1'b1;
      random_phase(180);
      drain();
      write_lifetime(16'd30000);
      send_idle_pct  = 31;
      recv_stall_pct = 31;
      random_phase(180);
      drain();
      write_lifetime(16'd6);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      random_phase(180);
      drain();

      $display("Sent %0d request transactions; %0d responses checked over six lifetimes.",
               sent, checked);
      $display("Covered insert, refresh, full table, lookup, expiry and unknown commands.");
      if (fail_count == 0 && pending == 0) begin
         $display("[aging_address_map_table_top] OK");
      end else begin
         $display("[aging_address_map_table_top] ERROR");
      end
      $finish;
   end

endmodule
